/* sv/swr_pkg.sv */
// ----------------------------------------------------------------------------
// swr_pkg
// Shared widths, codes, defaults and word types of the sliding window receiver.
// ----------------------------------------------------------------------------
package swr_pkg;

   // field widths
   localparam int SEQ_W      = 12;
   localparam int PAY_W      = 11;
   localparam int OFFSET_W   = 22;
   localparam int BYTES_W    = 23;
   localparam int NEXP_W     = 13;
   localparam int WIN_CFG_W  = 6;
   localparam int FRM_CFG_W  = 13;

   localparam logic [BYTES_W-1:0] BYTES_SAT = '1;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_PER_BUFFER = 1'd1;

   // reset register values
   localparam int WINDOW_RESET = 4;
   localparam int FRAMES_RESET = 16;

   // parameter defaults
   localparam int WINDOW_MAX_DEF  = 32;
   localparam int FRAME_BYTES_DEF = 1024;
   localparam int MAX_FRAMES_DEF  = 4096;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic             frame_bad;
      logic             end_of_transfer;
      logic [PAY_W-1:0] payload_bytes;
   } req_word_type;

   typedef struct packed {
      logic [SEQ_W-1:0]    ack_seq;
      logic                ack_negative;
      logic                store_payload;
      logic [OFFSET_W-1:0] store_offset;
      logic                buffer_complete;
      logic [BYTES_W-1:0]  buffer_bytes;
      logic                transfer_complete;
      logic [NEXP_W-1:0]   next_expected;
   } rsp_word_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_word_type;

endpackage

/* sv/swr_channels.sv */
// ----------------------------------------------------------------------------
// swr channels
// Valid/ready channels of the receiver: frame words in, result words out, and
// the register write channel.
// ----------------------------------------------------------------------------
interface swr_req_if;
   logic                        valid;
   logic                        ready;
   logic [swr_pkg::SEQ_W-1:0]   seq_num;
   logic                        frame_bad;
   logic                        end_of_transfer;
   logic [swr_pkg::PAY_W-1:0]   payload_bytes;

   modport source (output valid, seq_num, frame_bad, end_of_transfer, payload_bytes,
                   input ready);
   modport sink   (input valid, seq_num, frame_bad, end_of_transfer, payload_bytes,
                   output ready);
endinterface

interface swr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swr_pkg::SEQ_W-1:0]     ack_seq;
   logic                          ack_negative;
   logic                          store_payload;
   logic [swr_pkg::OFFSET_W-1:0]  store_offset;
   logic                          buffer_complete;
   logic [swr_pkg::BYTES_W-1:0]   buffer_bytes;
   logic                          transfer_complete;
   logic [swr_pkg::NEXP_W-1:0]    next_expected;

   modport source (output valid, ack_seq, ack_negative, store_payload, store_offset,
                   buffer_complete, buffer_bytes, transfer_complete, next_expected,
                   input ready);
   modport sink   (input valid, ack_seq, ack_negative, store_payload, store_offset,
                   buffer_complete, buffer_bytes, transfer_complete, next_expected,
                   output ready);
endinterface

interface swr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [swr_pkg::CSR_INDEX_W-1:0]   index;
   logic [swr_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/swr_slide.sv */
// ----------------------------------------------------------------------------
// swr_slide
// Window slide: finds the run of received frames just past the next expected
// one and shifts the receive mask past it.
// ----------------------------------------------------------------------------
module swr_slide #(
   parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEF
) (
   input  logic [WINDOW_MAX-1:0]            mask_cur,
   output logic [$clog2(WINDOW_MAX+1)-1:0]  shift,
   output logic [WINDOW_MAX-1:0]            mask_slid
);

   localparam int SH_W = $clog2(WINDOW_MAX+1);

   // bits at or above the window are always clear, so the first zero bounds the run
   always_comb begin
      shift = SH_W'(WINDOW_MAX);
      for (int i = WINDOW_MAX-1; i >= 1; i--) begin
         if (!mask_cur[i]) begin
            shift = SH_W'(i);
         end
      end
   end

   assign mask_slid = mask_cur >> shift;

endmodule

/* sv/swr_core.sv */
// ----------------------------------------------------------------------------
// swr_core
// Window state and per-frame step logic; registers are written on a step or
// on a register write.
// ----------------------------------------------------------------------------
module swr_core #(
   parameter int WINDOW_MAX  = swr_pkg::WINDOW_MAX_DEF,
   parameter int FRAME_BYTES = swr_pkg::FRAME_BYTES_DEF,
   parameter int MAX_FRAMES  = swr_pkg::MAX_FRAMES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  swr_pkg::req_word_type  item,
   input  swr_pkg::csr_word_type  csr,
   output swr_pkg::rsp_word_type  result
);

   localparam int SEQ_W     = swr_pkg::SEQ_W;
   localparam int BYTES_W   = swr_pkg::BYTES_W;
   localparam int SEQ_SPAN  = 2 ** SEQ_W;
   localparam int FRAME_CAP = (MAX_FRAMES > SEQ_SPAN) ? MAX_FRAMES : SEQ_SPAN;
   localparam int WIN_W     = $clog2(WINDOW_MAX+1);
   localparam int FRM_W     = $clog2(MAX_FRAMES+1);
   localparam int BFC_W     = $clog2(FRAME_CAP+1);
   localparam int EXP_W     = $clog2(FRAME_CAP+WINDOW_MAX+1);
   localparam int CMP_W     = EXP_W + 1;
   localparam int DIFF_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SH_W      = $clog2(WINDOW_MAX+1);
   localparam int FB_W      = $clog2(FRAME_BYTES+1);
   localparam int LEN_W     = ((SEQ_W+FB_W > BYTES_W) ? SEQ_W+FB_W : BYTES_W) + 1;
   localparam int FL_W      = (FRM_W+FB_W > BYTES_W) ? FRM_W+FB_W : BYTES_W;
   localparam int RST_WIN   = (swr_pkg::WINDOW_RESET > WINDOW_MAX) ?
                              WINDOW_MAX : swr_pkg::WINDOW_RESET;
   localparam int RST_FRM   = (swr_pkg::FRAMES_RESET > MAX_FRAMES) ?
                              MAX_FRAMES : swr_pkg::FRAMES_RESET;
   localparam int RST_PROD  = RST_FRM * FRAME_BYTES;
   localparam int RST_FULL  = (RST_PROD > (2**BYTES_W - 1)) ? (2**BYTES_W - 1) : RST_PROD;

   logic [WIN_W-1:0]      window_ff, window_in;
   logic [FRM_W-1:0]      frames_ff, frames_in;
   logic [BYTES_W-1:0]    full_len_ff, full_len_in;
   logic [WINDOW_MAX-1:0] mask_ff, mask_in;
   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [BFC_W-1:0]      bfc_ff, bfc_in;
   logic [BYTES_W-1:0]    final_len_ff, final_len_in;
   logic                  end_seen_ff, end_seen_in;
   logic                  finished_ff, finished_in;

   // register write values
   logic [swr_pkg::WIN_CFG_W-1:0] win_raw;
   logic [swr_pkg::FRM_CFG_W-1:0] frm_raw;
   logic [WIN_W-1:0]              win_eff;
   logic [FRM_W-1:0]              frm_eff;
   logic [WINDOW_MAX-1:0]         keep;
   logic [FL_W-1:0]               full_prod;
   logic [BYTES_W-1:0]            full_sat;

   // step values
   logic [CMP_W-1:0]      seq_c, exp_c, win_c, diff;
   logic [DIFF_W-1:0]     d;
   logic                  in_win;
   logic [LEN_W-1:0]      base, pay_c, len;
   logic [BYTES_W-1:0]    len_sat;
   logic [SEQ_W:0]        seq_inc;
   logic [SH_W-1:0]       shift;
   logic [WINDOW_MAX-1:0] mask_slid;
   logic                  store, complete;
   logic [BYTES_W-1:0]    bytes;

   swr_slide #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_slide (
      .mask_cur  (mask_ff),
      .shift     (shift),
      .mask_slid (mask_slid)
   );

   always_comb begin
      win_raw = csr.data[swr_pkg::WIN_CFG_W-1:0];
      if (win_raw == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(win_raw) > 32'(WINDOW_MAX)) begin
         win_eff = WIN_W'(WINDOW_MAX);
      end else begin
         win_eff = WIN_W'(win_raw);
      end
      for (int i = 0; i < WINDOW_MAX; i++) begin
         keep[i] = (32'(i) < 32'(win_eff));
      end

      frm_raw = csr.data[swr_pkg::FRM_CFG_W-1:0];
      if (frm_raw == '0) begin
         frm_eff = FRM_W'(1);
      end else if (32'(frm_raw) > 32'(MAX_FRAMES)) begin
         frm_eff = FRM_W'(MAX_FRAMES);
      end else begin
         frm_eff = FRM_W'(frm_raw);
      end
      full_prod = FL_W'(frm_eff) * FL_W'(FRAME_BYTES);
      if (full_prod > FL_W'(swr_pkg::BYTES_SAT)) begin
         full_sat = swr_pkg::BYTES_SAT;
      end else begin
         full_sat = full_prod[BYTES_W-1:0];
      end
   end

   always_comb begin
      seq_c   = CMP_W'(item.seq_num);
      exp_c   = CMP_W'(exp_ff);
      win_c   = CMP_W'(window_ff);
      diff    = seq_c - exp_c;
      d       = diff[DIFF_W-1:0];
      in_win  = !item.frame_bad && (seq_c < exp_c + win_c);
      seq_inc = {1'b0, item.seq_num} + 1'b1;

      base = LEN_W'(item.seq_num) * LEN_W'(FRAME_BYTES);
      if (LEN_W'(item.payload_bytes) > LEN_W'(FRAME_BYTES)) begin
         pay_c = LEN_W'(FRAME_BYTES);
      end else begin
         pay_c = LEN_W'(item.payload_bytes);
      end
      len = base + pay_c;
      if (len > LEN_W'(swr_pkg::BYTES_SAT)) begin
         len_sat = swr_pkg::BYTES_SAT;
      end else begin
         len_sat = len[BYTES_W-1:0];
      end
   end

   always_comb begin
      window_in    = window_ff;
      frames_in    = frames_ff;
      full_len_in  = full_len_ff;
      mask_in      = mask_ff;
      exp_in       = exp_ff;
      bfc_in       = bfc_ff;
      final_len_in = final_len_ff;
      end_seen_in  = end_seen_ff;
      finished_in  = finished_ff;
      store        = 1'b0;
      complete     = 1'b0;
      bytes        = '0;

      if (step) begin
         if (!finished_ff) begin
            if (in_win) begin
               if (seq_c == exp_c) begin
                  mask_in = mask_slid;
                  exp_in  = exp_ff + EXP_W'(shift);
                  store   = 1'b1;
               end else if (seq_c > exp_c) begin
                  if (!mask_ff[d]) begin
                     mask_in[d] = 1'b1;
                     store      = 1'b1;
                  end
               end
               if (item.end_of_transfer) begin
                  bfc_in       = BFC_W'(seq_inc);
                  final_len_in = len_sat;
                  end_seen_in  = 1'b1;
               end
            end
            if (exp_in >= EXP_W'(bfc_in)) begin
               complete = 1'b1;
               bytes    = final_len_in;
               if (end_seen_in) begin
                  finished_in = 1'b1;
               end
               mask_in      = '0;
               exp_in       = '0;
               bfc_in       = BFC_W'(frames_ff);
               final_len_in = full_len_ff;
            end
         end
      end else if (csr.valid) begin
         unique case (csr.index)
            swr_pkg::CSR_WINDOW_LENGTH: begin
               window_in = win_eff;
               mask_in   = mask_ff & keep;
            end
            swr_pkg::CSR_FRAMES_PER_BUFFER: begin
               frames_in   = frm_eff;
               full_len_in = full_sat;
               if (exp_ff == '0 && mask_ff == '0 && !end_seen_ff && !finished_ff) begin
                  bfc_in       = BFC_W'(frm_eff);
                  final_len_in = full_sat;
               end
            end
            default: begin
               window_in = window_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WIN_W'(RST_WIN);
         frames_ff    <= FRM_W'(RST_FRM);
         full_len_ff  <= BYTES_W'(RST_FULL);
         mask_ff      <= '0;
         exp_ff       <= '0;
         bfc_ff       <= BFC_W'(RST_FRM);
         final_len_ff <= BYTES_W'(RST_FULL);
         end_seen_ff  <= 1'b0;
         finished_ff  <= 1'b0;
      end else begin
         window_ff    <= window_in;
         frames_ff    <= frames_in;
         full_len_ff  <= full_len_in;
         mask_ff      <= mask_in;
         exp_ff       <= exp_in;
         bfc_ff       <= bfc_in;
         final_len_ff <= final_len_in;
         end_seen_ff  <= end_seen_in;
         finished_ff  <= finished_in;
      end
   end

   always_comb begin
      result.ack_seq           = item.seq_num;
      result.ack_negative      = item.frame_bad;
      result.store_payload     = store;
      result.store_offset      = store ? base[swr_pkg::OFFSET_W-1:0] : '0;
      result.buffer_complete   = complete;
      result.buffer_bytes      = bytes;
      result.transfer_complete = finished_in;
      result.next_expected     = exp_in[swr_pkg::NEXP_W-1:0];
   end

endmodule

/* sv/sliding_window_receiver.sv */
// ----------------------------------------------------------------------------
// sliding_window_receiver
// Selective-repeat receiver bookkeeping: acknowledge, store and window slide.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  : one parsed frame word per handshake (seq_num, frame_bad,
//               end_of_transfer, payload_bytes).
//   rsp_chan  : one result word per frame, in frame order: acknowledgement,
//               store strobe and byte offset, buffer completion and length,
//               transfer completion and the next expected sequence number.
//   csr_chan  : register writes, index 0 window_length, 1 frames_per_buffer;
//               always ready. Write only while no frame is in flight.
//   Path      : a word accepted into the input register steps the core once the
//               output register is free or being emptied; its result word is
//               registered in the output register and offered on rsp_chan.
//   Throughput: one frame per cycle while rsp_chan is not held off; the window
//               slide is a combinational run search and shift of the receive mask.
//   Reset     : synchronous; clears the window, mask and end/finish flags and
//               loads window 4 and 16 frames per buffer.
//   Stall     : while rsp_chan is held off, one more word is taken into the
//               input register, then req_chan.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module sliding_window_receiver #(
   parameter int WINDOW_MAX  = swr_pkg::WINDOW_MAX_DEF,
   parameter int FRAME_BYTES = swr_pkg::FRAME_BYTES_DEF,
   parameter int MAX_FRAMES  = swr_pkg::MAX_FRAMES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   swr_req_if.sink   req_chan,
   swr_rsp_if.source rsp_chan,
   swr_csr_if.sink   csr_chan
);

   swr_pkg::req_word_type in_ff, in_in;
   logic                  in_valid_ff, in_valid_in;
   swr_pkg::rsp_word_type out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   swr_pkg::rsp_word_type result;
   swr_pkg::csr_word_type csr_word;
   logic                  advance;
   logic                  req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      csr_word.valid = csr_chan.valid && csr_chan.ready;
      csr_word.index = csr_chan.index;
      csr_word.data  = csr_chan.data;
   end

   swr_core #(
      .WINDOW_MAX  (WINDOW_MAX),
      .FRAME_BYTES (FRAME_BYTES),
      .MAX_FRAMES  (MAX_FRAMES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .csr    (csr_word),
      .result (result)
   );

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_in.seq_num         = req_chan.seq_num;
         in_in.frame_bad       = req_chan.frame_bad;
         in_in.end_of_transfer = req_chan.end_of_transfer;
         in_in.payload_bytes   = req_chan.payload_bytes;
         in_valid_in           = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.ack_seq           = out_ff.ack_seq;
   assign rsp_chan.ack_negative      = out_ff.ack_negative;
   assign rsp_chan.store_payload     = out_ff.store_payload;
   assign rsp_chan.store_offset      = out_ff.store_offset;
   assign rsp_chan.buffer_complete   = out_ff.buffer_complete;
   assign rsp_chan.buffer_bytes      = out_ff.buffer_bytes;
   assign rsp_chan.transfer_complete = out_ff.transfer_complete;
   assign rsp_chan.next_expected     = out_ff.next_expected;

endmodule

/* bench/tb_sliding_window_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_receiver
// Self-checking bench for the sliding window receiver. Frame words go in as
// bursts with random gaps while the result side stalls on changing patterns.
// A window model kept in the bench predicts each acknowledgement, store strobe,
// byte offset and buffer completion; every result word is compared field by
// field. Directed frames cover the window edges, duplicates, bad frames, frames
// below the window, register writes and the end mark; random traffic follows.
// ----------------------------------------------------------------------------
module tb_sliding_window_receiver;

   localparam int SEQ_W         = swr_pkg::SEQ_W;
   localparam int PAY_W         = swr_pkg::PAY_W;
   localparam int OFFSET_W      = swr_pkg::OFFSET_W;
   localparam int BYTES_W       = swr_pkg::BYTES_W;
   localparam int NEXP_W        = swr_pkg::NEXP_W;
   localparam int WIN_CFG_W     = swr_pkg::WIN_CFG_W;
   localparam int FRM_CFG_W     = swr_pkg::FRM_CFG_W;
   localparam int CSR_DATA_W    = swr_pkg::CSR_DATA_W;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_WORDS   = 72;
   localparam int LARGE_FRAMES  = 8 * swr_pkg::WINDOW_MAX_DEF;
   localparam int PAY_TOP       = (1 << PAY_W) - 1;
   localparam int SEQ_TOP       = (1 << SEQ_W) - 1;

   logic clock;
   logic reset;

   swr_req_if req_chan();
   swr_rsp_if rsp_chan();
   swr_csr_if csr_chan();

   sliding_window_receiver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // window model
   logic [WIN_CFG_W-1:0] window_reg;
   logic [FRM_CFG_W-1:0] frames_reg;
   logic [63:0]          held_mask;
   int unsigned          next_seq;
   int unsigned          buffer_frames;
   int unsigned          buffer_length;
   bit                   end_marked;
   bit                   transfer_done;

   swr_pkg::rsp_word_type pending_acks[$];
   int unsigned  mismatches  = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left;
   int unsigned  gap_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned window_span();
      if (window_reg == '0) return 1;
      if (32'(window_reg) > swr_pkg::WINDOW_MAX_DEF) return swr_pkg::WINDOW_MAX_DEF;
      return 32'(window_reg);
   endfunction

   function automatic int unsigned clamp_bytes(input longint unsigned n);
      longint unsigned top;
      top = 64'(swr_pkg::BYTES_SAT);
      return (n > top) ? 32'(top) : 32'(n);
   endfunction

   function automatic void open_buffer();
      int unsigned frames;
      if (frames_reg == '0) frames = 1;
      else if (32'(frames_reg) > swr_pkg::MAX_FRAMES_DEF) frames = swr_pkg::MAX_FRAMES_DEF;
      else frames = 32'(frames_reg);
      held_mask     = '0;
      next_seq      = 0;
      buffer_frames = frames;
      buffer_length = clamp_bytes(64'(frames) * 64'(swr_pkg::FRAME_BYTES_DEF));
   endfunction

   function automatic swr_pkg::rsp_word_type receive_frame(input swr_pkg::req_word_type f);
      swr_pkg::rsp_word_type r;
      int unsigned     seq, pay, w, shift;
      longint unsigned base;
      seq  = 32'(f.seq_num);
      pay  = 32'(f.payload_bytes);
      if (pay > swr_pkg::FRAME_BYTES_DEF) pay = swr_pkg::FRAME_BYTES_DEF;
      w    = window_span();
      base = 64'(seq) * 64'(swr_pkg::FRAME_BYTES_DEF);
      r    = '0;
      r.ack_seq      = f.seq_num;
      r.ack_negative = f.frame_bad;
      if (!transfer_done) begin
         if (!f.frame_bad && seq < next_seq + w) begin
            if (seq == next_seq) begin
               shift = 1;
               while (shift < w && held_mask[shift]) shift++;
               held_mask = held_mask >> shift;
               next_seq += shift;
               r.store_payload = 1'b1;
            end else if (seq > next_seq && !held_mask[seq - next_seq]) begin
               held_mask[seq - next_seq] = 1'b1;
               r.store_payload = 1'b1;
            end
            if (r.store_payload) r.store_offset = OFFSET_W'(base);
            if (f.end_of_transfer) begin
               buffer_frames = seq + 1;
               buffer_length = clamp_bytes(base + 64'(pay));
               end_marked    = 1'b1;
            end
         end
         if (next_seq >= buffer_frames) begin
            r.buffer_complete = 1'b1;
            r.buffer_bytes    = BYTES_W'(buffer_length);
            if (end_marked) transfer_done = 1'b1;
            open_buffer();
         end
      end
      r.transfer_complete = transfer_done;
      r.next_expected     = NEXP_W'(next_seq);
      return r;
   endfunction

   function automatic swr_pkg::req_word_type frame_word(input int unsigned seq, input bit bad,
                                                       input bit eot, input int unsigned pay);
      swr_pkg::req_word_type f;
      f.seq_num         = SEQ_W'(seq);
      f.frame_bad       = bad;
      f.end_of_transfer = eot;
      f.payload_bytes   = PAY_W'(pay);
      return f;
   endfunction

   // Mostly frames the window wants, some duplicates, stale and stray ones.
   function automatic swr_pkg::req_word_type pick_frame();
      swr_pkg::req_word_type f;
      int unsigned  w, roll, seq;
      w    = window_span();
      roll = $urandom_range(0, 99);
      if (roll < 35) seq = next_seq;
      else if (roll < 65) seq = next_seq + $urandom_range(0, w - 1);
      else if (roll < 75) begin
         seq = next_seq;
         for (int i = 1; i < w; i++)
            if (held_mask[i] && (seq == next_seq || $urandom_range(0, 1))) seq = next_seq + i;
      end else if (roll < 85 && next_seq > 0) seq = $urandom_range(0, next_seq - 1);
      else seq = $urandom_range(0, SEQ_TOP);
      if (seq > SEQ_TOP) seq = next_seq;
      f.seq_num   = SEQ_W'(seq);
      f.frame_bad = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
         0:       f.payload_bytes = '0;
         1:       f.payload_bytes = PAY_W'(swr_pkg::FRAME_BYTES_DEF);
         2:       f.payload_bytes = PAY_W'($urandom_range(swr_pkg::FRAME_BYTES_DEF + 1,
                                                          PAY_TOP));
         default: f.payload_bytes = PAY_W'($urandom_range(0, swr_pkg::FRAME_BYTES_DEF));
      endcase
      // end mark only where it cannot close the transfer early
      f.end_of_transfer = (f.frame_bad || transfer_done || seq >= next_seq + w)
                          && $urandom_range(0, 3) == 0;
      return f;
   endfunction

   task automatic send_frame(input swr_pkg::req_word_type f);
      while (gap_left > 0) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      req_chan.valid           <= 1'b1;
      req_chan.seq_num         <= f.seq_num;
      req_chan.frame_bad       <= f.frame_bad;
      req_chan.end_of_transfer <= f.end_of_transfer;
      req_chan.payload_bytes   <= f.payload_bytes;
      do @(posedge clock); while (!req_chan.ready);
      pending_acks.push_back(receive_frame(f));
      if (burst_left > 1) burst_left--;
      else begin
         burst_left = $urandom_range(1, 40);
         gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
   endtask

   task automatic wait_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_acks.size() != 0);
   endtask

   task automatic write_csr(input logic [swr_pkg::CSR_INDEX_W-1:0] index,
                            input int unsigned value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_chan.ready);
      if (index == swr_pkg::CSR_WINDOW_LENGTH) begin
         window_reg = WIN_CFG_W'(value);
         held_mask &= (64'd1 << window_span()) - 64'd1;
      end else begin
         frames_reg = FRM_CFG_W'(value);
         if (next_seq == 0 && held_mask == 0 && !end_marked && !transfer_done) open_buffer();
      end
   endtask

   task automatic configure(input bit set_window, input int unsigned window_value,
                            input bit set_frames, input int unsigned frames_value);
      if (set_window) write_csr(swr_pkg::CSR_WINDOW_LENGTH, window_value);
      if (set_frames) write_csr(swr_pkg::CSR_FRAMES_PER_BUFFER, frames_value);
      csr_chan.valid <= 1'b0;
   endtask

   // in-order frames until the current buffer is closed and untouched again
   task automatic finish_buffer();
      while (next_seq != 0 || held_mask != 0)
         send_frame(frame_word(next_seq, 1'b0, 1'b0,
                               $urandom_range(0, swr_pkg::FRAME_BYTES_DEF)));
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
         mismatches++;
      end
   endtask

   task automatic test_reset_window();
      send_frame(frame_word(3, 1'b0, 1'b0, PAY_TOP));
      send_frame(frame_word(4, 1'b0, 1'b0, 9));
      send_frame(frame_word(SEQ_TOP, 1'b0, 1'b1, swr_pkg::FRAME_BYTES_DEF));
      send_frame(frame_word(2, 1'b1, 1'b1, 0));
      send_frame(frame_word(0, 1'b0, 1'b0, 0));
      send_frame(frame_word(1, 1'b0, 1'b0, swr_pkg::FRAME_BYTES_DEF));
      send_frame(frame_word(2, 1'b0, 1'b0, 512));
      send_frame(frame_word(2, 1'b0, 1'b0, 5));
   endtask

   // held frames past a shrunk window are dropped; frame count write is deferred
   task automatic test_window_shrink();
      send_frame(frame_word(6, 1'b0, 1'b0, 60));
      send_frame(frame_word(7, 1'b0, 1'b0, 70));
      wait_results();
      configure(1'b1, 0, 1'b1, 0);
      send_frame(frame_word(6, 1'b0, 1'b0, 61));
      send_frame(frame_word(4, 1'b0, 1'b0, 40));
   endtask

   task automatic test_buffer_rollover();
      wait_results();
      configure(1'b1, (1 << WIN_CFG_W) - 1, 1'b0, 0);
      for (int s = 15; s >= 5; s--)
         send_frame(frame_word(s, 1'b0, 1'b0, 100 + s));
      send_frame(frame_word(0, 1'b0, 1'b0, 7));
   endtask

   task automatic test_large_buffer();
      int unsigned order[swr_pkg::WINDOW_MAX_DEF];
      int unsigned pick, hold;
      wait_results();
      finish_buffer();
      wait_results();
      configure(1'b1, swr_pkg::WINDOW_MAX_DEF, 1'b1, LARGE_FRAMES);
      for (int base = 0; base < LARGE_FRAMES; base += swr_pkg::WINDOW_MAX_DEF) begin
         for (int i = 0; i < swr_pkg::WINDOW_MAX_DEF; i++) order[i] = base + i;
         for (int i = swr_pkg::WINDOW_MAX_DEF - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            hold        = order[i];
            order[i]    = order[pick];
            order[pick] = hold;
         end
         foreach (order[i])
            send_frame(frame_word(order[i], 1'b0, 1'b0,
                                  $urandom_range(0, swr_pkg::FRAME_BYTES_DEF)));
      end
   endtask

   task automatic test_random_traffic();
      int unsigned win, frames;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_results();
         case ($urandom_range(0, 5))
            0:       win = 0;
            1:       win = 1;
            2:       win = swr_pkg::WINDOW_MAX_DEF;
            3:       win = (1 << WIN_CFG_W) - 1;
            default: win = $urandom_range(2, swr_pkg::WINDOW_MAX_DEF - 1);
         endcase
         case ($urandom_range(0, 19))
            0:       frames = 0;
            1:       frames = 1;
            2:       frames = $urandom_range(41, 64);
            default: frames = $urandom_range(2, 40);
         endcase
         configure(p % 4 != 1, win, p % 4 != 2, frames);
         repeat (PHASE_WORDS) send_frame(pick_frame());
      end
   endtask

   task automatic test_end_of_transfer();
      wait_results();
      finish_buffer();
      wait_results();
      configure(1'b1, 8, 1'b1, swr_pkg::MAX_FRAMES_DEF);
      send_frame(frame_word(0, 1'b0, 1'b0, 1));
      send_frame(frame_word(1, 1'b0, 1'b0, 2));
      send_frame(frame_word(4, 1'b0, 1'b0, 3));
      // duplicate inside the window still carries its end mark
      send_frame(frame_word(4, 1'b0, 1'b1, 100));
      // end mark below the window closes the transfer at once
      send_frame(frame_word(1, 1'b0, 1'b1, swr_pkg::FRAME_BYTES_DEF));
      repeat (10) send_frame(pick_frame());
      wait_results();
      configure(1'b1, 2, 1'b0, 0);
      repeat (5) send_frame(pick_frame());
   endtask

   initial begin : result_checker
      swr_pkg::rsp_word_type seen, want;
      int unsigned  phase, stretch;
      logic [7:0]   ready_pattern;
      phase         = 0;
      stretch       = 0;
      ready_pattern = '1;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            seen.ack_seq           = rsp_chan.ack_seq;
            seen.ack_negative      = rsp_chan.ack_negative;
            seen.store_payload     = rsp_chan.store_payload;
            seen.store_offset      = rsp_chan.store_offset;
            seen.buffer_complete   = rsp_chan.buffer_complete;
            seen.buffer_bytes      = rsp_chan.buffer_bytes;
            seen.transfer_complete = rsp_chan.transfer_complete;
            seen.next_expected     = rsp_chan.next_expected;
            if (pending_acks.size() == 0) begin
               $display("%0t: result word with none expected, expected none, got seq %0d",
                        $time, seen.ack_seq);
               mismatches++;
            end else begin
               want = pending_acks.pop_front();
               compare_field("ack_seq", 32'(want.ack_seq), 32'(seen.ack_seq));
               compare_field("ack_negative", 32'(want.ack_negative),
                             32'(seen.ack_negative));
               compare_field("store_payload", 32'(want.store_payload),
                             32'(seen.store_payload));
               compare_field("store_offset", 32'(want.store_offset),
                             32'(seen.store_offset));
               compare_field("buffer_complete", 32'(want.buffer_complete),
                             32'(seen.buffer_complete));
               compare_field("buffer_bytes", 32'(want.buffer_bytes),
                             32'(seen.buffer_bytes));
               compare_field("transfer_complete", 32'(want.transfer_complete),
                             32'(seen.transfer_complete));
               compare_field("next_expected", 32'(want.next_expected),
                             32'(seen.next_expected));
            end
         end
         if (stretch == 0) begin
            stretch       = $urandom_range(16, 200);
            ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         end
         stretch--;
         rsp_chan.ready <= ready_pattern[phase % 8];
         phase++;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.seq_num         <= '0;
      req_chan.frame_bad       <= 1'b0;
      req_chan.end_of_transfer <= 1'b0;
      req_chan.payload_bytes   <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.index           <= swr_pkg::CSR_WINDOW_LENGTH;
      csr_chan.data            <= '0;
      window_reg    = WIN_CFG_W'(swr_pkg::WINDOW_RESET);
      frames_reg    = FRM_CFG_W'(swr_pkg::FRAMES_RESET);
      end_marked    = 1'b0;
      transfer_done = 1'b0;
      open_buffer();
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_window_shrink();
      test_buffer_rollover();
      test_large_buffer();
      test_random_traffic();
      test_end_of_transfer();

      wait_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_acks.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
